FILE: rtl/core/pbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Polyline unit package
// Action codes, status codes and controller command types.
// ---------------------------------------------------------------------------
package pbp_pkg;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_HIT   = 2'd1;
    localparam logic [1:0] ACT_BBOX  = 2'd2;
    localparam logic [1:0] ACT_PERIM = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic start;
        logic write_vertex;
        logic clear_result;
        logic load_a;
        logic seg_start;
        logic bbox_first;
        logic bbox_step;
        logic inc_count;
    } t_cmd;

    typedef struct packed {
        logic seg_done;
        logic seg_hit;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/core/pbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Polyline datapath
// Vertex memories, bounding-box registers and a multi-cycle segment unit
// that computes either the hit test or the floor square-root length.
// ---------------------------------------------------------------------------
module pbp_datapath #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 20,
    parameter int AW           = 8,
    parameter int CW           = 9
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  pbp_pkg::t_cmd               i_cmd,
    input  wire [1:0]                   i_action,
    input  wire [AW-1:0]                i_rd_addr,
    input  wire [AW-1:0]                i_wr_addr,
    input  wire signed [COORD_BITS-1:0] i_x,
    input  wire signed [COORD_BITS-1:0] i_y,
    input  wire [15:0]                  i_tol,
    output pbp_pkg::t_stat              o_stat,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic [31:0]                 o_perim,
    output logic [CW-1:0]               o_count
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW + 1;
    localparam int TW = (SW > 32) ? SW : 32;
    localparam int HW = (TW + 1) / 2;
    localparam int QW = 4 * DW + 40;
    localparam int RB = DW + 1;
    localparam int SBW = $clog2(RB + 1);

    logic signed [COORD_BITS-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y, r_ax, r_ay, r_px, r_py;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_vertex) begin
            r_mem_x[i_wr_addr] <= i_x;
            r_mem_y[i_wr_addr] <= i_y;
        end
        r_rd_x <= r_mem_x[i_rd_addr];
        r_rd_y <= r_mem_y[i_rd_addr];
        if (i_cmd.start) begin
            r_px <= i_x;
            r_py <= i_y;
        end
        if (i_cmd.load_a) begin
            r_ax <= r_rd_x;
            r_ay <= r_rd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.inc_count) begin
            r_count <= r_count + CW'(1);
        end
    end
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_result) begin
            o_min_x <= '0;
            o_min_y <= '0;
            o_max_x <= '0;
            o_max_y <= '0;
        end else if (i_cmd.bbox_first) begin
            o_min_x <= r_rd_x;
            o_max_x <= r_rd_x;
            o_min_y <= r_rd_y;
            o_max_y <= r_rd_y;
        end else if (i_cmd.bbox_step) begin
            if (r_rd_x < o_min_x) o_min_x <= r_rd_x;
            if (r_rd_x > o_max_x) o_max_x <= r_rd_x;
            if (r_rd_y < o_min_y) o_min_y <= r_rd_y;
            if (r_rd_y > o_max_y) o_max_y <= r_rd_y;
        end
    end

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_DEC, S_CROSS, S_CSQ, S_CMP, S_SQRT, S_DONE
    } t_seg;

    t_seg r_seg;
    logic signed [DW-1:0] r_dx, r_dy, r_vx, r_vy, r_wx, r_wy;
    logic signed [SW-1:0] r_dot;
    logic [SW-1:0] r_len2, r_v2, r_w2;
    logic [TW-1:0] r_tol2;
    logic signed [SW-1:0] r_cross;
    logic [QW-1:0] r_lhs, r_rhs;
    logic [1:0] r_ph;
    logic [RB-1:0] r_root;
    logic [SBW-1:0] r_bit;
    logic r_hit;
    logic [RB-1:0] w_cand;
    logic [2*RB-1:0] w_cand2;

    assign w_cand  = r_root | (RB'(1) << r_bit);
    assign w_cand2 = w_cand * w_cand;

    // The squared cross product and the tolerance-length product are built
    // from half-width digit products, one pair of digits per cycle.
    logic [2*HW-1:0] w_cx, w_tx, w_lx;
    logic [HW-1:0] w_c0, w_c1, w_t0, w_l1;
    logic [2*HW-1:0] w_pl, w_pr;
    logic [QW-1:0] w_pl_sh, w_pr_sh;

    assign w_cx = (2*HW)'($unsigned(r_cross));
    assign w_tx = (2*HW)'(r_tol2);
    assign w_lx = (2*HW)'(r_len2);
    assign w_c0 = r_ph[1] ? w_cx[2*HW-1:HW] : w_cx[HW-1:0];
    assign w_c1 = r_ph[0] ? w_cx[2*HW-1:HW] : w_cx[HW-1:0];
    assign w_t0 = r_ph[1] ? w_tx[2*HW-1:HW] : w_tx[HW-1:0];
    assign w_l1 = r_ph[0] ? w_lx[2*HW-1:HW] : w_lx[HW-1:0];
    assign w_pl = w_c0 * w_c1;
    assign w_pr = w_t0 * w_l1;

    always_comb begin
        case (r_ph)
            2'd0: begin
                w_pl_sh = QW'(w_pl);
                w_pr_sh = QW'(w_pr);
            end
            2'd3: begin
                w_pl_sh = QW'(w_pl) << (2 * HW);
                w_pr_sh = QW'(w_pr) << (2 * HW);
            end
            default: begin
                w_pl_sh = QW'(w_pl) << HW;
                w_pr_sh = QW'(w_pr) << HW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= S_IDLE;
        end else begin
            case (r_seg)
                S_IDLE: begin
                    if (i_cmd.seg_start) begin
                        r_dx  <= DW'(r_rd_x) - DW'(r_ax);
                        r_dy  <= DW'(r_rd_y) - DW'(r_ay);
                        r_vx  <= DW'(r_px) - DW'(r_ax);
                        r_vy  <= DW'(r_py) - DW'(r_ay);
                        r_wx  <= DW'(r_px) - DW'(r_rd_x);
                        r_wy  <= DW'(r_py) - DW'(r_rd_y);
                        r_hit <= 1'b0;
                        r_seg <= S_M1;
                    end
                end
                S_M1: begin
                    r_len2 <= SW'(r_dx * r_dx) + SW'(r_dy * r_dy);
                    r_tol2 <= TW'(i_tol) * TW'(i_tol);
                    if (i_action == pbp_pkg::ACT_PERIM) begin
                        r_root <= '0;
                        r_bit  <= SBW'(RB - 1);
                        r_seg  <= S_SQRT;
                    end else begin
                        r_seg <= S_M2;
                    end
                end
                S_M2: begin
                    r_dot <= SW'(r_vx * r_dx) + SW'(r_vy * r_dy);
                    r_v2  <= SW'(r_vx * r_vx) + SW'(r_vy * r_vy);
                    r_w2  <= SW'(r_wx * r_wx) + SW'(r_wy * r_wy);
                    r_seg <= S_DEC;
                end
                S_DEC: begin
                    if (r_len2 == '0) begin
                        r_hit <= 1'b0;
                        r_seg <= S_DONE;
                    end else if (r_dot <= 0) begin
                        r_hit <= (r_v2 <= r_tol2);
                        r_seg <= S_DONE;
                    end else if (r_dot >= $signed(r_len2)) begin
                        r_hit <= (r_w2 <= r_tol2);
                        r_seg <= S_DONE;
                    end else begin
                        r_seg <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    r_cross <= SW'(r_vx * r_dy) - SW'(r_vy * r_dx);
                    r_seg <= S_CSQ;
                end
                S_CSQ: begin
                    r_cross <= r_cross < 0 ? -r_cross : r_cross;
                    r_lhs   <= '0;
                    r_rhs   <= '0;
                    r_ph    <= 2'd0;
                    r_seg   <= S_M3;
                end
                S_M3: begin
                    r_lhs <= r_lhs + w_pl_sh;
                    r_rhs <= r_rhs + w_pr_sh;
                    if (r_ph == 2'd3) begin
                        r_seg <= S_CMP;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                S_CMP: begin
                    r_hit <= (r_lhs <= r_rhs);
                    r_seg <= S_DONE;
                end
                S_SQRT: begin
                    if (SW'(w_cand2) <= r_len2 && (w_cand2 >> SW) == '0) begin
                        r_root <= w_cand;
                    end
                    if (r_bit == '0) begin
                        r_seg <= S_DONE;
                    end else begin
                        r_bit <= r_bit - SBW'(1);
                    end
                end
                S_DONE: r_seg <= S_IDLE;
                default: r_seg <= S_IDLE;
            endcase
        end
    end

    logic [32:0] w_psum;
    assign w_psum = {1'b0, o_perim} + 33'(r_root);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_result) begin
            o_perim <= '0;
        end else if (r_seg == S_DONE && i_action == pbp_pkg::ACT_PERIM) begin
            o_perim <= w_psum[32] ? 32'hFFFF_FFFF : w_psum[31:0];
        end
    end

    assign o_stat.seg_done = (r_seg == S_DONE);
    assign o_stat.seg_hit  = r_hit;

endmodule
`default_nettype wire

FILE: rtl/core/pbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Polyline controller
// Sequences the vertex walk for each request and drives the result handshake.
// ---------------------------------------------------------------------------
module pbp_ctrl #(
    parameter int MAX_VERTICES = 256,
    parameter int AW           = 8,
    parameter int CW           = 9
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  wire [1:0]     i_action,
    input  wire [CW-1:0]  i_count,
    input  pbp_pkg::t_stat i_stat,
    output pbp_pkg::t_cmd o_cmd,
    output logic [1:0]    o_act,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic          o_valid,
    input  wire           i_out_ready,
    output logic [1:0]    o_status,
    output logic          o_hit
);
    typedef enum logic [2:0] {
        S_IDLE, S_RD0, S_LOADA, S_BBOX, S_SEG, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic r_first;
    logic w_acc;

    assign o_ready = (r_state == S_IDLE) && (!o_valid || i_out_ready);
    assign w_acc   = i_valid && o_ready;
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_wr_addr = i_count[AW-1:0];

    always_comb begin
        o_cmd = '0;
        o_cmd.start = w_acc;
        o_cmd.clear_result = w_acc;
        o_cmd.write_vertex = w_acc && i_action == pbp_pkg::ACT_ADD &&
                             i_count < CW'(MAX_VERTICES);
        o_cmd.inc_count = o_cmd.write_vertex;
        o_cmd.bbox_first = (r_state == S_BBOX) && r_first;
        o_cmd.bbox_step  = (r_state == S_BBOX) && !r_first;
        o_cmd.load_a     = (r_state == S_LOADA) ||
                           (r_state == S_NEXT && i_stat.seg_done);
        o_cmd.seg_start  = (r_state == S_SEG) && !r_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            o_status <= pbp_pkg::ST_OK;
            o_hit    <= 1'b0;
            o_act    <= pbp_pkg::ACT_ADD;
            r_idx    <= '0;
            r_n      <= '0;
            r_first  <= 1'b0;
        end else begin
            if (o_valid && i_out_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        o_act    <= i_action;
                        o_hit    <= 1'b0;
                        o_status <= pbp_pkg::ST_OK;
                        r_n      <= i_count;
                        r_idx    <= '0;
                        r_first  <= 1'b1;
                        if (i_action == pbp_pkg::ACT_ADD) begin
                            if (i_count >= CW'(MAX_VERTICES))
                                o_status <= pbp_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else if (i_count == '0) begin
                            o_status <= pbp_pkg::ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    if (o_act == pbp_pkg::ACT_BBOX) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_BBOX;
                    end else begin
                        r_state <= S_LOADA;
                    end
                end
                S_LOADA: begin
                    if (r_n == CW'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SEG;
                    end
                end
                S_BBOX: begin
                    r_first <= 1'b0;
                    if (r_idx >= r_n) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_SEG: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (i_stat.seg_done) begin
                        if (o_act == pbp_pkg::ACT_HIT && i_stat.seg_hit) begin
                            o_hit   <= 1'b1;
                            r_state <= S_OUT;
                        end else if (r_idx + CW'(1) >= r_n) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_first <= 1'b1;
                            r_state <= S_SEG;
                        end
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/polyline_hit_bbox_perimeter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Polyline hit, bounding-box and perimeter unit
// Stores one polyline and answers hit, box and perimeter requests.
// ---------------------------------------------------------------------------
// Requests are handled one at a time: a new request is taken only when the
// unit is idle and its previous response has been taken. A bounding-box
// request reads one vertex per cycle. Hit-test and perimeter requests fetch
// the next vertex for each segment and then run the segment unit on it: a
// hit test needs no cross product when the segment has zero length or the
// point projects beyond an end, and otherwise compares the squared cross
// product, built from narrow multiplies, and it stops at the first hit; a
// perimeter request runs the bit-serial square root for each segment. A
// stalled response holds off the next request.
module polyline_hit_bbox_perimeter_unit #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 20
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [15:0]                   i_cfg_wdata,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [1:0]                    i_action,
    input  wire signed [COORD_BITS-1:0]  i_x_coord,
    input  wire signed [COORD_BITS-1:0]  i_y_coord,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [1:0]                   o_status,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic [31:0]                  o_perimeter,
    output logic [8:0]                   o_vertex_count
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [15:0] r_tol;
    pbp_pkg::t_cmd  w_cmd;
    pbp_pkg::t_stat w_stat;
    logic [1:0] w_act;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [CW-1:0] w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd80;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    pbp_ctrl #(.MAX_VERTICES(MAX_VERTICES), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_count(w_count), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_act(w_act), .o_rd_addr(w_rd_addr), .o_wr_addr(w_wr_addr),
        .o_valid(o_valid), .i_out_ready(i_ready), .o_status(o_status),
        .o_hit(o_hit)
    );

    pbp_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS),
                   .AW(AW), .CW(CW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_action(w_act),
        .i_rd_addr(w_rd_addr), .i_wr_addr(w_wr_addr), .i_x(i_x_coord),
        .i_y(i_y_coord), .i_tol(r_tol), .o_stat(w_stat), .o_min_x(o_min_x),
        .o_min_y(o_min_y), .o_max_x(o_max_x), .o_max_y(o_max_y),
        .o_perim(o_perimeter), .o_count(w_count)
    );

    assign o_vertex_count = 9'(w_count);
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Polyline unit testbench
// Streams add, hit-test, bounding-box and perimeter requests into the unit
// with random gaps and stalls on both sides. A local predictor works out each
// response, and the responses are checked field by field as they arrive.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_VTX     = 256;
    localparam int          CBITS       = 20;
    localparam longint      CYCLE_LIMIT = 50_000_000;
    localparam int          DRAIN_WAIT  = 40;

    typedef struct {
        logic [1:0]        action;
        logic [CBITS-1:0]  x;
        logic [CBITS-1:0]  y;
    } t_request;

    typedef struct {
        logic [1:0]        status;
        logic              hit;
        logic [CBITS-1:0]  min_x;
        logic [CBITS-1:0]  min_y;
        logic [CBITS-1:0]  max_x;
        logic [CBITS-1:0]  max_y;
        logic [31:0]       perimeter;
        logic [8:0]        vertex_count;
    } t_response;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = pbp_pkg::ACT_ADD;
    logic [CBITS-1:0]   i_x_coord = '0;
    logic [CBITS-1:0]   i_y_coord = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic               o_hit;
    logic [CBITS-1:0]   o_min_x;
    logic [CBITS-1:0]   o_min_y;
    logic [CBITS-1:0]   o_max_x;
    logic [CBITS-1:0]   o_max_y;
    logic [31:0]        o_perimeter;
    logic [8:0]         o_vertex_count;

    polyline_hit_bbox_perimeter_unit #(
        .MAX_VERTICES (MAX_VTX),
        .COORD_BITS   (CBITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_min_x        (o_min_x),
        .o_min_y        (o_min_y),
        .o_max_x        (o_max_x),
        .o_max_y        (o_max_y),
        .o_perimeter    (o_perimeter),
        .o_vertex_count (o_vertex_count)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor state, updated as each request is accepted.
    longint    poly_x [MAX_VTX];
    longint    poly_y [MAX_VTX];
    int        poly_count = 0;
    logic [15:0] tolerance = 16'd80;

    // Generator shadow of the polyline, used to aim hit-test points.
    longint    gen_x [MAX_VTX];
    longint    gen_y [MAX_VTX];
    int        gen_count = 0;

    t_request  pending_requests [$];
    t_response awaited_responses [$];

    int        errors = 0;
    int        hits_seen = 0;
    int        drops_seen = 0;
    int        responses_seen = 0;
    longint    cycle_count = 0;
    bit        quiet_driver = 1'b0;
    bit        quiet_sink = 1'b0;

    function automatic logic [127:0] sq_dist(longint a, longint b);
        logic [127:0] ua;
        logic [127:0] ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        return ua * ua + ub * ub;
    endfunction

    function automatic bit segment_near(longint px, longint py, int idx,
                                        logic [127:0] tol_sq);
        longint       dx;
        longint       dy;
        longint       vx;
        longint       vy;
        longint       dot;
        longint       cross_val;
        logic [127:0] len_sq;
        logic [127:0] cross_mag;
        dx = poly_x[idx+1] - poly_x[idx];
        dy = poly_y[idx+1] - poly_y[idx];
        vx = px - poly_x[idx];
        vy = py - poly_y[idx];
        if (dx == 0 && dy == 0) begin
            return 1'b0;
        end
        len_sq = sq_dist(dx, dy);
        dot = vx * dx + vy * dy;
        if (dot <= 0) begin
            return sq_dist(vx, vy) <= tol_sq;
        end
        if (dot >= longint'(len_sq)) begin
            return sq_dist(px - poly_x[idx+1], py - poly_y[idx+1]) <= tol_sq;
        end
        cross_val = vx * dy - vy * dx;
        cross_mag = (cross_val < 0) ? -cross_val : cross_val;
        return cross_mag * cross_mag <= tol_sq * len_sq;
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] cand;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= n) begin
                root = cand;
            end
        end
        return root[63:0];
    endfunction

    function automatic t_response polyline_answer(t_request rq);
        t_response    r;
        longint       px;
        longint       py;
        longint       mnx;
        longint       mny;
        longint       mxx;
        longint       mxy;
        logic [127:0] tol_sq;
        logic [63:0]  total;
        px = longint'(signed'(rq.x));
        py = longint'(signed'(rq.y));
        r = '{default: '0};
        if (rq.action == pbp_pkg::ACT_ADD) begin
            if (poly_count >= MAX_VTX) begin
                r.status = pbp_pkg::ST_FULL;
            end else begin
                poly_x[poly_count] = px;
                poly_y[poly_count] = py;
                poly_count++;
            end
        end else if (poly_count == 0) begin
            r.status = pbp_pkg::ST_EMPTY;
        end else if (rq.action == pbp_pkg::ACT_HIT) begin
            tol_sq = 128'(tolerance) * 128'(tolerance);
            for (int i = 0; i + 1 < poly_count && !r.hit; i++) begin
                if (segment_near(px, py, i, tol_sq)) begin
                    r.hit = 1'b1;
                end
            end
        end else if (rq.action == pbp_pkg::ACT_BBOX) begin
            mnx = poly_x[0];
            mxx = poly_x[0];
            mny = poly_y[0];
            mxy = poly_y[0];
            for (int i = 1; i < poly_count; i++) begin
                if (poly_x[i] < mnx) mnx = poly_x[i];
                if (poly_x[i] > mxx) mxx = poly_x[i];
                if (poly_y[i] < mny) mny = poly_y[i];
                if (poly_y[i] > mxy) mxy = poly_y[i];
            end
            r.min_x = mnx[CBITS-1:0];
            r.min_y = mny[CBITS-1:0];
            r.max_x = mxx[CBITS-1:0];
            r.max_y = mxy[CBITS-1:0];
        end else begin
            total = '0;
            for (int i = 0; i + 1 < poly_count; i++) begin
                total += floor_root(sq_dist(poly_x[i+1] - poly_x[i],
                                            poly_y[i+1] - poly_y[i]));
                if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            end
            r.perimeter = total[31:0];
        end
        r.vertex_count = poly_count[8:0];
        return r;
    endfunction

    task automatic queue_request(logic [1:0] act, longint x, longint y);
        t_request rq;
        rq.action = act;
        rq.x = x[CBITS-1:0];
        rq.y = y[CBITS-1:0];
        if (act == pbp_pkg::ACT_ADD && gen_count < MAX_VTX) begin
            gen_x[gen_count] = longint'(signed'(rq.x));
            gen_y[gen_count] = longint'(signed'(rq.y));
            gen_count++;
        end
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    function automatic longint any_coord();
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(0, 1000)) - 500;
            1: return longint'($urandom_range(0, 40000)) - 20000;
            default: return longint'(signed'(20'($urandom)));
        endcase
    endfunction

    // Hit-test point aimed at a random stored segment, or anywhere.
    task automatic queue_query(int span);
        int     i;
        longint t;
        longint px;
        longint py;
        if (gen_count >= 2 && $urandom_range(0, 3) != 0) begin
            i = $urandom_range(0, gen_count - 2);
            t = $urandom_range(0, 20);
            px = gen_x[i] + ((gen_x[i+1] - gen_x[i]) * t) / 16
                 + longint'($urandom_range(0, 2 * span)) - span;
            py = gen_y[i] + ((gen_y[i+1] - gen_y[i]) * t) / 16
                 + longint'($urandom_range(0, 2 * span)) - span;
            if (px > 524287) px = 524287;
            if (px < -524288) px = -524288;
            if (py > 524287) py = 524287;
            if (py < -524288) py = -524288;
            queue_request(pbp_pkg::ACT_HIT, px, py);
        end else begin
            queue_request(pbp_pkg::ACT_HIT, any_coord(), any_coord());
        end
    endtask

    // Sampled on the falling edge, when every request and response has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid ||
               awaited_responses.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tolerance = value;
    endtask

    task automatic random_phase(int n_items, int add_pct, int span);
        int roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                if ($urandom_range(0, 2) == 0 && gen_count > 0) begin
                    queue_request(pbp_pkg::ACT_ADD,
                        gen_x[gen_count-1] + longint'($urandom_range(0, 400)) - 200,
                        gen_y[gen_count-1] + longint'($urandom_range(0, 400)) - 200);
                end else begin
                    queue_request(pbp_pkg::ACT_ADD, any_coord(), any_coord());
                end
            end else if (roll < add_pct + (100 - add_pct) / 2) begin
                queue_query(span);
            end else begin
                queue_request($urandom_range(0, 1) ? pbp_pkg::ACT_BBOX : pbp_pkg::ACT_PERIM,
                              any_coord(), any_coord());
            end
        end
    endtask

    // Request driver.
    int        send_gap = 0;
    t_request  next_rq;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid) begin
                awaited_responses.insert(awaited_responses.size(),
                    polyline_answer('{i_action, i_x_coord, i_y_coord}));
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                next_rq = pending_requests.pop_front();
                i_action <= next_rq.action;
                i_x_coord <= next_rq.x;
                i_y_coord <= next_rq.y;
                i_valid <= 1'b1;
                send_gap <= quiet_driver ? 0 : $urandom_range(0, 9);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Response monitor.
    int        sink_stall = 0;
    t_response want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                responses_seen++;
                if (awaited_responses.size() == 0) begin
                    $error("Response arrived with no request outstanding.");
                    errors++;
                end else begin
                    want = awaited_responses.pop_front();
                    if (o_hit === 1'b1) hits_seen++;
                    if (o_status === pbp_pkg::ST_FULL) drops_seen++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        errors++;
                    end
                    if (o_min_x !== want.min_x) begin
                        $error("min_x: expected %h, got %h", want.min_x, o_min_x);
                        errors++;
                    end
                    if (o_min_y !== want.min_y) begin
                        $error("min_y: expected %h, got %h", want.min_y, o_min_y);
                        errors++;
                    end
                    if (o_max_x !== want.max_x) begin
                        $error("max_x: expected %h, got %h", want.max_x, o_max_x);
                        errors++;
                    end
                    if (o_max_y !== want.max_y) begin
                        $error("max_y: expected %h, got %h", want.max_y, o_max_y);
                        errors++;
                    end
                    if (o_perimeter !== want.perimeter) begin
                        $error("perimeter: expected %0d, got %0d", want.perimeter,
                               o_perimeter);
                        errors++;
                    end
                    if (o_vertex_count !== want.vertex_count) begin
                        $error("vertex_count: expected %0d, got %0d", want.vertex_count,
                               o_vertex_count);
                        errors++;
                    end
                end
                sink_stall = quiet_sink ? 0 : $urandom_range(0, 9);
            end
            if (sink_stall != 0) begin
                sink_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store, single vertex, exact tolerance, zero-length segment
        // and coordinate extremes.
        queue_request(pbp_pkg::ACT_HIT, 0, 0);
        queue_request(pbp_pkg::ACT_BBOX, 0, 0);
        queue_request(pbp_pkg::ACT_PERIM, 0, 0);
        queue_request(pbp_pkg::ACT_ADD, 0, 0);
        queue_request(pbp_pkg::ACT_HIT, 0, 0);
        queue_request(pbp_pkg::ACT_PERIM, 0, 0);
        queue_request(pbp_pkg::ACT_BBOX, 0, 0);
        queue_request(pbp_pkg::ACT_ADD, 160, 0);
        queue_request(pbp_pkg::ACT_HIT, 80, 80);
        queue_request(pbp_pkg::ACT_HIT, 80, 81);
        queue_request(pbp_pkg::ACT_HIT, 240, 0);
        queue_request(pbp_pkg::ACT_HIT, 241, 0);
        queue_request(pbp_pkg::ACT_HIT, -80, 0);
        queue_request(pbp_pkg::ACT_HIT, -48, -64);
        queue_request(pbp_pkg::ACT_ADD, 160, 0);
        queue_request(pbp_pkg::ACT_HIT, 160, 81);
        queue_request(pbp_pkg::ACT_PERIM, 0, 0);
        queue_request(pbp_pkg::ACT_ADD, -524288, 524287);
        queue_request(pbp_pkg::ACT_ADD, 524287, -524288);
        queue_request(pbp_pkg::ACT_BBOX, 0, 0);
        queue_request(pbp_pkg::ACT_PERIM, 0, 0);
        queue_request(pbp_pkg::ACT_HIT, 524287, 524287);
        queue_request(pbp_pkg::ACT_HIT, -524288, -524288);
        wait_idle();

        set_tolerance(16'd0);
        queue_request(pbp_pkg::ACT_HIT, 80, 0);
        queue_request(pbp_pkg::ACT_HIT, 80, 1);
        random_phase(150, 10, 40);
        wait_idle();

        set_tolerance(16'hFFFF);
        quiet_driver = 1'b1;
        random_phase(150, 10, 30000);
        wait_idle();

        set_tolerance(16'd80);
        quiet_driver = 1'b0;
        quiet_sink = 1'b1;
        random_phase(200, 12, 200);
        wait_idle();

        set_tolerance(16'($urandom_range(1, 4000)));
        quiet_sink = 1'b0;
        random_phase(250, 10, 3000);
        wait_idle();

        set_tolerance(16'd16);
        random_phase(200, 10, 60);
        wait_idle();

        // Fill the store, run past full and query it at full size.
        set_tolerance(16'($urandom_range(100, 65535)));
        while (gen_count < MAX_VTX) begin
            random_phase(1, 85, 5000);
        end
        random_phase(120, 50, 5000);
        wait_idle();

        $display("Checked %0d responses; %0d hits, %0d dropped vertices, %0d stored.",
                 responses_seen, hits_seen, drops_seen, poly_count);
        $display("Tolerance swept over zero, reset value, mid values and full scale.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
